// File: rtl/core/ptp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, mode codes, control structs and helpers for the perceptron.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int FEATURES_DEF = 4;   // default lane count
  localparam int FEAT_MAX     = 4;   // feature slots carried in tdata
  localparam int FEAT_W       = 16;  // Q4.12 feature
  localparam int WGT_W        = 24;  // Q12.12 weight and bias
  localparam int LR_W         = 16;  // learning rate, 12 fraction bits
  localparam int FRAC         = 12;
  localparam int SLR_W        = LR_W + 2;           // signed +/- learning rate
  localparam int PROD_W       = FEAT_W + WGT_W;     // feature * weight
  localparam int DLT_W        = SLR_W + FEAT_W;     // signed rate * feature
  localparam int ACC_W        = PROD_W + 3;         // four products plus bias
  localparam int ACT_W        = 32;
  localparam int MODE_W       = 2;

  localparam logic [LR_W-1:0]   LR_RESET     = 16'd41;
  localparam logic [MODE_W-1:0] MODE_PREDICT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRAIN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd2;

  // Stage-two command to every lane.
  typedef struct packed {
    logic upd;    // apply the learning step
    logic load;   // copy the held feature into the weight
  } lane_ctl_t;

  // Stage-two command to the merge stage.
  typedef struct packed {
    logic valid;
    logic train;
    logic load;
    logic label;
  } mrg_ctl_t;

  // Merge stage decision.
  typedef struct packed {
    logic                    pred;
    logic                    wrong;
    logic signed [ACT_W-1:0] act;
  } mrg_res_t;

  // Clamp a one-bit-grown sum back to the weight width.
  function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [WGT_W:0] v);
    logic signed [WGT_W-1:0] res;
    if (v[WGT_W] != v[WGT_W-1]) begin
      res = v[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      res = v[WGT_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ptp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_lane
// One feature lane: holds its weight, forms the dot-product term and the
// learning step, and writes the weight back on a training mistake or on load.
// ----------------------------------------------------------------------------
module ptp_lane
  import ptp_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       acc_en,
  input  wire  signed [FEAT_W-1:0]  feature,
  input  wire  signed [SLR_W-1:0]   slr,
  input  lane_ctl_t                 ctl,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [WGT_W-1:0]  weight_r, weight_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DLT_W-1:0]  dlt_r;
  logic signed [FEAT_W-1:0] feat_r;

  logic signed [DLT_W-FRAC-1:0] dlt_sh;
  logic signed [WGT_W:0]        wsum;

  // Floor to 12 fraction bits is the arithmetic drop of the low bits.
  assign dlt_sh = dlt_r[DLT_W-1:FRAC];
  assign wsum   = (WGT_W+1)'(weight_r) + (WGT_W+1)'(dlt_sh);

  always_comb begin
    weight_nxt = weight_r;
    if (ctl.load) begin
      weight_nxt = WGT_W'(feat_r);
    end else if (ctl.upd) begin
      weight_nxt = sat_wgt(wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      prod_r <= PROD_W'(feature * weight_r);
      dlt_r  <= DLT_W'(slr * feature);
      feat_r <= feature;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// File: rtl/core/ptp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_merge
// Sum the lane terms with the bias, decide the class, and update or clear the bias.
// ----------------------------------------------------------------------------
module ptp_merge
  import ptp_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEF
)
(
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [FEATURES-1:0][PROD_W-1:0] prods,
  input  wire  signed [SLR_W-1:0]        slr,
  input  mrg_ctl_t                       ctl,
  output mrg_res_t                       res
);

  logic signed [WGT_W-1:0] bias_r, bias_nxt;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [WGT_W:0]   bsum;

  // Scale the bias to 24 fraction bits, keeping its sign.
  always_comb begin
    acc = ACC_W'($signed({bias_r, {FRAC{1'b0}}}));
    for (int i = 0; i < FEATURES; i++) begin
      acc = acc + ACC_W'($signed(prods[i]));
    end
  end

  // The floored sum has at most 31 significant bits, so it always fits the
  // 32-bit activation and clamping never engages.
  assign acc_sh    = acc >>> FRAC;
  assign res.act   = acc_sh[ACT_W-1:0];
  assign res.pred  = ~acc[ACC_W-1];
  assign res.wrong = ctl.train & (res.pred != ctl.label);

  assign bsum = (WGT_W+1)'(bias_r) + (WGT_W+1)'(slr);

  always_comb begin
    bias_nxt = bias_r;
    if (ctl.valid && ctl.load) begin
      bias_nxt = '0;
    end else if (ctl.valid && res.wrong) begin
      bias_nxt = sat_wgt(bsum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else begin
      bias_r <= bias_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/perceptron_train_predict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perceptron_train_predict
// Single-layer perceptron with predict, train and weight-load modes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser: mode, label; tdata: 4 features
//  out_    | master    | out_tvalid/out_tready| tuser: pred, miscl; tdata: activation
//  cfg_    | write     | cfg_we               | cfg_wdata: learning rate
//
//  An item is registered first in the lanes as the lane products (feature *
//  weight and signed rate * feature); from there the merge step sums the
//  lane terms with the bias, writes weights and bias, and loads the result.
//  The weight feedback loop holds off a new item until the last is merged.
//  rst_n is synchronous, active low; it zeroes weights and bias and sets the
//  learning rate to 41. A stalled result holds in the output register; the
//  input is ready with stage two empty and that register empty or draining on that edge.
// ----------------------------------------------------------------------------
module perceptron_train_predict
  import ptp_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEF
)
(
  input  wire                     clk,
  input  wire                     rst_n,
  // configuration
  input  wire                     cfg_we,
  input  wire  [LR_W-1:0]         cfg_wdata,
  // input stream
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [FEAT_MAX*FEAT_W-1:0] in_tdata,  // feature_0, feature_1, feature_2, feature_3
  input  wire  [2:0]              in_tuser,     // mode[1:0], label_positive[2]
  // result stream
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [ACT_W-1:0]        out_tdata,    // activation_value
  output logic [1:0]              out_tuser     // prediction_positive[0], misclassified[1]
);

  logic [LR_W-1:0]          lr_r;
  logic                     b_vld_r;
  logic [MODE_W-1:0]        mode_r;
  logic                     label_r;
  logic signed [SLR_W-1:0]  slr_r;
  logic signed [SLR_W-1:0]  slr_in;

  logic                     out_vld_r;
  logic [ACT_W-1:0]         out_data_r;
  logic [1:0]               out_user_r;

  logic                     in_xfer;
  lane_ctl_t                lane_ctl;
  mrg_ctl_t                 mrg_ctl;
  mrg_res_t                 mrg_res;
  logic [FEATURES-1:0][PROD_W-1:0] prods;

  // Take a new item only with stage two empty and the output free next cycle.
  assign in_tready = ~b_vld_r & (~out_vld_r | out_tready);
  assign in_xfer   = in_tvalid & in_tready;

  // Signed learning step: sign follows the label.
  assign slr_in = in_tuser[2] ? SLR_W'({1'b0, lr_r}) : -SLR_W'({1'b0, lr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
    end else if (cfg_we) begin
      lr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= in_xfer;
    end
  end

  // Hold the item's control for stage two.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_tuser[1:0];
      label_r <= in_tuser[2];
      slr_r   <= slr_in;
    end
  end

  // Mode 3 has no meaning and falls through as predict.
  always_comb begin
    mrg_ctl.valid = b_vld_r;
    mrg_ctl.label = label_r;
    mrg_ctl.train = 1'b0;
    mrg_ctl.load  = 1'b0;
    case (mode_r)
      MODE_TRAIN: mrg_ctl.train = 1'b1;
      MODE_LOAD:  mrg_ctl.load  = 1'b1;
      default:    ;
    endcase
  end

  assign lane_ctl.upd  = b_vld_r & mrg_res.wrong;
  assign lane_ctl.load = b_vld_r & mrg_ctl.load;

  // Lanes: one per active feature.
  for (genvar g = 0; g < FEATURES; g++) begin : g_lane
    ptp_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .acc_en  (in_xfer),
      .feature ($signed(in_tdata[g*FEAT_W +: FEAT_W])),
      .slr     (slr_in),
      .ctl     (lane_ctl),
      .prod    (prods[g])
    );
  end

  ptp_merge #(
    .FEATURES (FEATURES)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .prods (prods),
    .slr   (slr_r),
    .ctl   (mrg_ctl),
    .res   (mrg_res)
  );

  // Output register: load from stage two, drop on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_vld_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      out_data_r <= mrg_res.act;
      out_user_r <= {mrg_res.wrong, mrg_res.pred};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire
